// ----- rtl/csr_sparse_residual_macros.svh -----
// Assertion shorthands shared by the residual block.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef CSR_SPARSE_RESIDUAL_MACROS_SVH
`define CSR_SPARSE_RESIDUAL_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CSRRES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define CSRRES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/csrres_pkg.sv -----
package csrres_pkg;

    localparam int COL_BITS  = 10;
    localparam int RES_BITS  = 32;
    localparam int OPND_BITS = 32;
    localparam int ACC_BITS  = 64;
    localparam int FRAC_BITS = 16;

    // Output queue: results queued plus results still in the pipeline.
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_BITS = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_BITS = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_NONZERO = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    // Control of one accepted transaction, handed to the datapath.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic col_ok;
    } t_issue;

    // One finished row.
    typedef struct packed {
        logic [COL_BITS-1:0]        row_number;
        logic signed [RES_BITS-1:0] residual;
        logic                       clipped;
    } t_result;

endpackage

// ----- rtl/csrres_xmem.sv -----
module csrres_xmem #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int ADDR_BITS    = 10,
    parameter int VALUE_BITS   = 32
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [ADDR_BITS-1:0]         i_wr_addr,
    input  logic signed [VALUE_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0]         i_rd_addr,
    output logic signed [VALUE_BITS-1:0] o_rd_data
);

    logic signed [VALUE_BITS-1:0] r_mem [VECTOR_DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- rtl/csrres_mac.sv -----
module csrres_mac
    import csrres_pkg::*;
#(
    parameter int VECTOR_DEPTH = 1024,
    parameter int VALUE_BITS   = 32,
    parameter int ROW_BITS     = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_issue                       i_issue,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic signed [VALUE_BITS-1:0] i_x_data,
    output logic                         o_push,
    output t_result                      o_result,
    output logic [1:0]                   o_pending
);

`include "csr_sparse_residual_macros.svh"

    localparam int PROD_BITS = 2 * VALUE_BITS;
    localparam int SH_BITS   = ACC_BITS - FRAC_BITS;
    localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(VECTOR_DEPTH - 1);
    localparam logic signed [SH_BITS-1:0] RES_MAX =
        SH_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SH_BITS-1:0] RES_MIN = -RES_MAX - SH_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // Stage 1: x read in flight
    logic                         r_s1_valid;
    t_cmd                         r_s1_cmd;
    logic                         r_s1_col_ok;
    logic signed [VALUE_BITS-1:0] r_s1_value;

    // Stage 2: product ready, accumulator update
    logic                         r_s2_valid;
    t_cmd                         r_s2_cmd;
    logic signed [VALUE_BITS-1:0] r_s2_value;
    logic signed [PROD_BITS-1:0]  r_prod;

    logic signed [ACC_BITS-1:0]   r_acc, n_acc;
    logic                         r_ovf, n_ovf;
    logic [ROW_BITS-1:0]          r_row, n_row;

    logic signed [VALUE_BITS-1:0] x_eff;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [ACC_BITS-1:0]   prod_ext;
    logic signed [ACC_BITS-1:0]   diff;
    logic                         sub_ovf;
    logic signed [SH_BITS-1:0]    shifted;
    logic signed [VALUE_BITS-1:0] res_val;
    logic                         res_sat;
    logic [ROW_BITS+COL_BITS-1:0] row_ext;

    // Advance the control bits of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        r_s1_cmd    <= i_issue.cmd;
        r_s1_col_ok <= i_issue.col_ok;
        r_s1_value  <= i_value;
        r_s2_cmd    <= r_s1_cmd;
        r_s2_value  <= r_s1_value;
        r_prod      <= prod;
    end

    // Multiply; a column past the vector reads as zero
    assign x_eff = r_s1_col_ok ? i_x_data : '0;
    assign prod  = r_s1_value * x_eff;

    // Saturating subtract of the product
    assign prod_ext = ACC_BITS'(r_prod);
    assign diff     = r_acc - prod_ext;
    assign sub_ovf  = (r_acc[ACC_BITS-1] != prod_ext[ACC_BITS-1]) &&
                      (diff[ACC_BITS-1] != r_acc[ACC_BITS-1]);

    // Row end: drop fraction bits, clamp to the value range
    assign shifted = r_acc[ACC_BITS-1:FRAC_BITS];
    always_comb begin
        res_sat = 1'b0;
        res_val = shifted[VALUE_BITS-1:0];
        if (shifted > RES_MAX) begin
            res_val = RES_MAX[VALUE_BITS-1:0];
            res_sat = 1'b1;
        end else if (shifted < RES_MIN) begin
            res_val = RES_MIN[VALUE_BITS-1:0];
            res_sat = 1'b1;
        end
    end

    assign row_ext             = (ROW_BITS + COL_BITS)'(r_row);
    assign o_result.row_number = row_ext[COL_BITS-1:0];
    assign o_result.residual   = RES_BITS'(res_val);
    assign o_result.clipped    = r_ovf | res_sat;
    assign o_push              = r_s2_valid && (r_s2_cmd == CMD_END);

    assign o_pending = {1'b0, r_s1_valid && (r_s1_cmd == CMD_END)} +
                       {1'b0, r_s2_valid && (r_s2_cmd == CMD_END)};

    // Accumulator, overflow flag and row counter
    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_row = r_row;
        if (r_s2_valid) begin
            case (r_s2_cmd)
                CMD_START: begin
                    n_acc = ACC_BITS'(r_s2_value) <<< FRAC_BITS;
                    n_ovf = 1'b0;
                end
                CMD_NONZERO: begin
                    if (sub_ovf) begin
                        n_acc = r_acc[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = diff;
                    end
                end
                CMD_END: begin
                    n_acc = '0;
                    n_ovf = 1'b0;
                    n_row = (r_row == ROW_LAST) ? '0 : r_row + ROW_BITS'(1);
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_row <= '0;
        end else begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_row <= n_row;
        end
    end

    `CSRRES_ASSERT_NEXT(a_end_clears, r_s2_valid && (r_s2_cmd == CMD_END), (r_acc == '0) && !r_ovf, "row end did not clear accumulator")
    `CSRRES_ASSERT_NEXT(a_start_loads, r_s2_valid && (r_s2_cmd == CMD_START), (r_acc[FRAC_BITS-1:0] == '0) && !r_ovf, "row start left fraction bits or overflow")
    `CSRRES_ASSERT_NOW(a_row_range, 1'b1, r_row <= ROW_LAST, "row counter past vector depth")

endmodule

// ----- rtl/csrres_ofifo.sv -----
module csrres_ofifo
    import csrres_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  t_result                   i_result,
    input  logic                      i_pop,
    output logic                      o_valid,
    output t_result                   o_result,
    output logic [OFIFO_CNT_BITS-1:0] o_count
);

`include "csr_sparse_residual_macros.svh"

    t_result                   r_slot [OFIFO_DEPTH];
    logic [OFIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [OFIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [OFIFO_CNT_BITS-1:0] r_count;
    logic                      pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign o_valid  = (r_count != '0);
    assign o_result = r_slot[r_rd_ptr];
    assign o_count  = r_count;

    // Store a finished row
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_result;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OFIFO_PTR_BITS'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_PTR_BITS'(1);
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + OFIFO_CNT_BITS'(1);
                2'b01:   r_count <= r_count - OFIFO_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `CSRRES_ASSERT_NOW(a_no_overflow, i_push, (r_count < OFIFO_CNT_BITS'(OFIFO_DEPTH)) || pop_ok, "push into full result queue")

endmodule

// ----- rtl/csr_sparse_residual.sv -----
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_cmd, i_column, i_operand
// result    out        o_valid / i_stall  o_row_number, o_residual, o_clipped
//
// One transaction per cycle while o_stall is low; a row-end result is pushed
// into the output queue after the x read, then the multiply, then the accumulate.
// Reset (i_rst_n low at a clock edge) clears the pipeline, the accumulator,
// the row counter and the result queue; the x store keeps its contents.
// o_stall rises when four results are queued or still in the pipeline,
// which holds under a long output stall; it never looks at i_stall.
module csr_sparse_residual
    import csrres_pkg::*;
#(
    parameter int VECTOR_DEPTH = 1024,
    parameter int VALUE_BITS   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_cmd,
    input  logic [COL_BITS-1:0]        i_column,
    input  logic signed [OPND_BITS-1:0] i_operand,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [COL_BITS-1:0]        o_row_number,
    output logic signed [RES_BITS-1:0] o_residual,
    output logic                       o_clipped
);

`include "csr_sparse_residual_macros.svh"

    localparam int ADDR_BITS = $clog2(VECTOR_DEPTH);
    localparam int CEXT_BITS = COL_BITS + ADDR_BITS;
    localparam int OUTS_BITS = OFIFO_CNT_BITS + 1;

    logic                         accept;
    t_cmd                         cmd;
    logic [CEXT_BITS-1:0]         col_ext;
    logic                         col_ok;
    logic [ADDR_BITS-1:0]         addr;
    logic signed [VALUE_BITS-1:0] value;
    logic signed [VALUE_BITS-1:0] x_data;
    t_issue                       issue;
    logic                         push;
    t_result                      result;
    t_result                      head;
    logic [1:0]                   pending;
    logic [OFIFO_CNT_BITS-1:0]    q_count;
    logic [OUTS_BITS-1:0]         outstanding;

    // Decode the incoming transaction
    assign accept  = i_valid && !o_stall;
    assign cmd     = t_cmd'(i_cmd);
    assign col_ext = CEXT_BITS'(i_column);
    assign col_ok  = col_ext < CEXT_BITS'(VECTOR_DEPTH);
    assign addr    = col_ext[ADDR_BITS-1:0];
    assign value   = i_operand[VALUE_BITS-1:0];

    assign issue.valid  = accept;
    assign issue.cmd    = cmd;
    assign issue.col_ok = col_ok;

    // Hold input while the queue could not take every result in flight
    assign outstanding = OUTS_BITS'(q_count) + OUTS_BITS'(pending);
    assign o_stall     = outstanding >= OUTS_BITS'(OFIFO_DEPTH);

    csrres_xmem #(
        .VECTOR_DEPTH(VECTOR_DEPTH),
        .ADDR_BITS   (ADDR_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_xmem (
        .i_clk    (i_clk),
        .i_wr_en  (accept && (cmd == CMD_LOAD) && col_ok),
        .i_wr_addr(addr),
        .i_wr_data(value),
        .i_rd_addr(addr),
        .o_rd_data(x_data)
    );

    csrres_mac #(
        .VECTOR_DEPTH(VECTOR_DEPTH),
        .VALUE_BITS  (VALUE_BITS),
        .ROW_BITS    (ADDR_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_value  (value),
        .i_x_data (x_data),
        .o_push   (push),
        .o_result (result),
        .o_pending(pending)
    );

    csrres_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_result(result),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_result(head),
        .o_count (q_count)
    );

    assign o_row_number = head.row_number;
    assign o_residual   = head.residual;
    assign o_clipped    = head.clipped;

    `CSRRES_ASSERT_NOW(a_outstanding_bound, 1'b1, outstanding <= OUTS_BITS'(OFIFO_DEPTH), "more results in flight than queue slots")
    `CSRRES_ASSERT_NEXT(a_full_stalls, outstanding == OUTS_BITS'(OFIFO_DEPTH), !push || q_count != '0, "queue state lost while full")

endmodule
